// ===== rtl/osp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package osp_pkg;

  // Fixed field widths and table depth.
  localparam int POS_BITS = 40;
  localparam int TOT_W = 32;
  localparam int OFF_W = 21;
  localparam int TBL_DEPTH = 100;
  localparam int TBL_AW = 7;

  // Item classes as sorted by the front part.
  localparam logic [1:0] CLS_BYTE = 2'd0;
  localparam logic [1:0] CLS_LAST = 2'd1;
  localparam logic [1:0] CLS_QUERY = 2'd2;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_OGG = 2'd1;
  localparam logic [1:0] ST_BAD_PACKET = 2'd2;
  localparam logic [1:0] ST_NO_TABLE = 2'd3;

  typedef struct packed {
    logic                mode;
    logic [7:0]          header_byte;
    logic                header_last;
    logic [POS_BITS-1:0] sample_pos;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    logic [1:0]          parse_status;
    logic                table_ready;
    logic [POS_BITS-1:0] byte_pos;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          cls;
    logic [7:0]          header_byte;
    logic [POS_BITS-1:0] sample_pos;
  } q_item_t;

  typedef struct packed {
    logic                start;
    logic                take;
    logic [POS_BITS-1:0] sample_pos;
    logic [TOT_W-1:0]    samples;
    logic [TOT_W-1:0]    bytes;
  } lkp_req_t;

  typedef struct packed {
    logic                done;
    logic [POS_BITS-1:0] byte_pos;
  } lkp_rsp_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [OFF_W-1:0]  data;
  } tbl_wr_t;

  localparam logic [13:0] STEP_ROM [256] = '{
    14'd0, 14'd112, 14'd197, 14'd327, 14'd374, 14'd394, 14'd407, 14'd417, 14'd425, 14'd433,
    14'd439, 14'd444, 14'd449, 14'd454, 14'd458, 14'd462, 14'd466, 14'd470, 14'd473, 14'd477,
    14'd480, 14'd483, 14'd486, 14'd489, 14'd491, 14'd494, 14'd497, 14'd499, 14'd502, 14'd504,
    14'd506, 14'd509, 14'd511, 14'd513, 14'd515, 14'd517, 14'd519, 14'd521, 14'd523, 14'd525,
    14'd527, 14'd529, 14'd531, 14'd533, 14'd535, 14'd537, 14'd538, 14'd540, 14'd542, 14'd544,
    14'd545, 14'd547, 14'd549, 14'd550, 14'd552, 14'd554, 14'd555, 14'd557, 14'd558, 14'd560,
    14'd562, 14'd563, 14'd565, 14'd566, 14'd568, 14'd569, 14'd571, 14'd572, 14'd574, 14'd575,
    14'd577, 14'd578, 14'd580, 14'd581, 14'd583, 14'd584, 14'd585, 14'd587, 14'd588, 14'd590,
    14'd591, 14'd593, 14'd594, 14'd595, 14'd597, 14'd598, 14'd599, 14'd601, 14'd602, 14'd604,
    14'd605, 14'd606, 14'd608, 14'd609, 14'd610, 14'd612, 14'd613, 14'd615, 14'd616, 14'd617,
    14'd619, 14'd620, 14'd621, 14'd623, 14'd624, 14'd625, 14'd627, 14'd628, 14'd629, 14'd631,
    14'd632, 14'd634, 14'd635, 14'd636, 14'd638, 14'd639, 14'd640, 14'd642, 14'd643, 14'd644,
    14'd646, 14'd647, 14'd649, 14'd650, 14'd651, 14'd653, 14'd654, 14'd655, 14'd657, 14'd658,
    14'd660, 14'd661, 14'd662, 14'd664, 14'd665, 14'd667, 14'd668, 14'd669, 14'd671, 14'd672,
    14'd674, 14'd675, 14'd677, 14'd678, 14'd679, 14'd681, 14'd682, 14'd684, 14'd685, 14'd687,
    14'd688, 14'd690, 14'd691, 14'd693, 14'd694, 14'd696, 14'd697, 14'd699, 14'd700, 14'd702,
    14'd704, 14'd705, 14'd707, 14'd708, 14'd710, 14'd712, 14'd713, 14'd715, 14'd716, 14'd718,
    14'd720, 14'd721, 14'd723, 14'd725, 14'd727, 14'd728, 14'd730, 14'd732, 14'd734, 14'd735,
    14'd737, 14'd739, 14'd741, 14'd743, 14'd745, 14'd747, 14'd748, 14'd750, 14'd752, 14'd754,
    14'd756, 14'd758, 14'd760, 14'd763, 14'd765, 14'd767, 14'd769, 14'd771, 14'd773, 14'd776,
    14'd778, 14'd780, 14'd782, 14'd785, 14'd787, 14'd790, 14'd792, 14'd795, 14'd797, 14'd800,
    14'd803, 14'd805, 14'd808, 14'd811, 14'd814, 14'd817, 14'd820, 14'd823, 14'd826, 14'd829,
    14'd833, 14'd836, 14'd840, 14'd843, 14'd847, 14'd851, 14'd855, 14'd859, 14'd863, 14'd868,
    14'd872, 14'd877, 14'd882, 14'd887, 14'd893, 14'd898, 14'd904, 14'd911, 14'd918, 14'd925,
    14'd933, 14'd941, 14'd951, 14'd961, 14'd972, 14'd985, 14'd1000, 14'd1017, 14'd1039,
    14'd1067, 14'd1108, 14'd1183, 14'd1520, 14'd2658, 14'd4666, 14'd8191
  };

  function automatic logic [13:0] step_rom(input logic [7:0] idx);
    return STEP_ROM[idx];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/osp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module osp_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/osp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module osp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire osp_pkg::in_item_t  req,
  output logic                    q_valid,
  output osp_pkg::q_item_t        q_item,
  input  wire logic               q_pop
);
  import osp_pkg::*;

  q_item_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  q_item_t    cls_item;

  // Classify the incoming transaction before it is queued.
  always_comb begin
    cls_item.header_byte = req.header_byte;
    cls_item.sample_pos = req.sample_pos;
    if (req.mode == MODE_QUERY) begin
      cls_item.cls = CLS_QUERY;
    end else if (req.header_last) begin
      cls_item.cls = CLS_LAST;
    end else begin
      cls_item.cls = CLS_BYTE;
    end
  end

  assign req_stall = (count == 2'd2);
  assign push = req_valid && !req_stall;
  assign q_valid = (count != 2'd0);
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/osp_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
module osp_lookup #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire osp_pkg::lkp_req_t             req,
  output osp_pkg::lkp_rsp_t                  rsp,
  output logic [osp_pkg::TBL_AW-1:0]         tbl_addr,
  input  wire logic [osp_pkg::OFF_W-1:0]     tbl_data
);
  import osp_pkg::*;

  localparam int NW = POS_BITS + 7 + FRAC_BITS;
  localparam int HW = NW - FRAC_BITS;
  localparam int MW = NW + 22;
  localparam int VW = MW + 1;
  localparam int PW = VW - 1 + TOT_W;
  localparam int SH = FRAC_BITS + 16;
  localparam int CW = $clog2(NW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_RD0 = 4'd3;
  localparam logic [3:0] S_RD1 = 4'd4;
  localparam logic [3:0] S_RD2 = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_ADD = 4'd7;
  localparam logic [3:0] S_MUL2 = 4'd8;
  localparam logic [3:0] S_SAT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]             state;
  logic [CW-1:0]          cnt;
  logic [NW-1:0]          num;
  logic [TOT_W-1:0]       rem;
  logic [TOT_W-1:0]       divisor;
  logic [TOT_W-1:0]       zm;
  logic [TBL_AW-1:0]      k;
  logic                   tneg;
  logic [NW-1:0]          tm;
  logic signed [OFF_W-1:0] prev;
  logic                   dneg;
  logic [21:0]            dm;
  logic [MW-1:0]          mcand;
  logic [MW-1:0]          acc1;
  logic [PW-1:0]          mcand2;
  logic [PW-1:0]          acc2;
  logic [POS_BITS-1:0]    res;

  logic [POS_BITS+6:0]    p100;
  logic [TOT_W:0]         trial;
  logic                   ge;
  logic [HW-1:0]          hi;
  logic [TBL_AW-1:0]      k_c;
  logic [NW-1:0]          kq;
  logic [OFF_W:0]         d;
  logic signed [VW-1:0]   t1s;
  logic signed [VW-1:0]   t2s;
  logic signed [VW-1:0]   vs;
  logic [PW-SH-1:0]       shifted;

  always_comb begin
    p100 = ({7'd0, req.sample_pos} << 6) + ({7'd0, req.sample_pos} << 5)
         + ({7'd0, req.sample_pos} << 2);
    trial = {rem, num[NW-1]};
    ge = (trial >= {1'b0, divisor});
    hi = num[NW-1:FRAC_BITS];
    if (hi > HW'(99)) begin
      k_c = TBL_AW'(99);
    end else if (hi == '0) begin
      k_c = TBL_AW'(1);
    end else begin
      k_c = hi[TBL_AW-1:0];
    end
    kq = NW'(k_c) << FRAC_BITS;
    d = {tbl_data[OFF_W-1], tbl_data} - {prev[OFF_W-1], prev};
    t1s = (dneg ^ tneg) ? -$signed({1'b0, acc1}) : $signed({1'b0, acc1});
    t2s = $signed({{(VW-OFF_W){prev[OFF_W-1]}}, prev}) <<< FRAC_BITS;
    vs = t1s + t2s;
    shifted = acc2[PW-1:SH];
    tbl_addr = (state == S_RD0) ? k - TBL_AW'(1) : k;
  end

  assign rsp.done = (state == S_DONE);
  assign rsp.byte_pos = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            num <= NW'(p100) << FRAC_BITS;
            rem <= '0;
            divisor <= req.samples;
            zm <= req.bytes;
            cnt <= CW'(NW);
            state <= S_DIV;
          end
        end
        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          rem <= ge ? TOT_W'(trial - {1'b0, divisor}) : trial[TOT_W-1:0];
          num <= {num[NW-2:0], ge};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          k <= k_c;
          tneg <= (num < kq);
          tm <= (num < kq) ? kq - num : num - kq;
          state <= S_RD0;
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          prev <= tbl_data;
          state <= S_RD2;
        end
        S_RD2: begin
          dneg <= d[OFF_W];
          dm <= d[OFF_W] ? 22'(-d) : 22'(d);
          mcand <= MW'(tm);
          acc1 <= '0;
          cnt <= CW'(22);
          state <= S_MUL1;
        end
        S_MUL1: begin
          if (dm[0]) begin
            acc1 <= acc1 + mcand;
          end
          mcand <= mcand << 1;
          dm <= dm >> 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (vs[VW-1] || vs == '0) begin
            res <= '0;
            state <= S_DONE;
          end else begin
            mcand2 <= PW'(vs[VW-2:0]);
            acc2 <= '0;
            cnt <= CW'(TOT_W);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (zm[0]) begin
            acc2 <= acc2 + mcand2;
          end
          mcand2 <= mcand2 << 1;
          zm <= zm >> 1;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          res <= (|shifted[PW-SH-1:POS_BITS]) ? '1 : shifted[POS_BITS-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (req.take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/osp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module osp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire osp_pkg::q_item_t     q_item,
  output logic                      q_pop,
  output osp_pkg::lkp_req_t         lkp_req,
  input  wire osp_pkg::lkp_rsp_t    lkp_rsp,
  output osp_pkg::tbl_wr_t          tbl_wr,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output osp_pkg::out_item_t        rsp
);
  import osp_pkg::*;

  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_LENLO = 3'd1;
  localparam logic [2:0] PH_LENHI = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_SEEK = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;
  localparam logic [16:0] COUNT_MAX = 17'd131071;
  localparam logic [7:0] MARKER = 8'h81;
  localparam logic [17:0] HDR_LEN = 18'd27;
  localparam logic [15:0] SEEK_SEG_LEN = 16'd110;

  logic [2:0]              phase, phase_next;
  logic [16:0]             byte_count, byte_count_next;
  logic [7:0]              seg_count, seg_count_next;
  logic [15:0]             pkt_len, pkt_len_next;
  logic [15:0]             seg_rem, seg_rem_next;
  logic [6:0]              data_idx, data_idx_next;
  logic [TOT_W-1:0]        pend_samples, pend_samples_next;
  logic [TOT_W-1:0]        pend_size, pend_size_next;
  logic [OFF_W-1:0]        run_off, run_off_next;
  logic [1:0]              err, err_next;
  logic [TOT_W-1:0]        total_samples, total_samples_next;
  logic [TOT_W-1:0]        total_bytes, total_bytes_next;
  logic                    table_valid, table_valid_next;
  logic                    busy;

  logic                    out_free;
  logic                    tbl_ok;
  logic                    step;
  logic                    report;
  logic                    qzero;
  logic                    start;
  logic                    load;
  logic                    sat;
  logic [7:0]              b;
  logic [17:0]             p;
  logic [17:0]             pstart;
  logic [17:0]             pend;
  logic [17:0]             size;
  logic [17:0]             pstart_n;
  logic [15:0]             len;
  logic [15:0]             rem_dec;
  logic [7:0]              magic;
  logic [1:0]              status;
  out_item_t               out_next;

  assign out_free = !rsp_valid || !rsp_stall;
  assign tbl_ok = table_valid && (total_bytes != '0);
  assign sat = (byte_count == COUNT_MAX);
  assign b = q_item.header_byte;

  always_comb begin
    q_pop = 1'b0;
    if (q_valid && !busy) begin
      unique case (q_item.cls)
        CLS_BYTE:  q_pop = 1'b1;
        CLS_LAST:  q_pop = out_free;
        CLS_QUERY: q_pop = tbl_ok ? 1'b1 : out_free;
        default:   q_pop = 1'b0;
      endcase
    end
  end

  assign step = q_pop && (q_item.cls != CLS_QUERY) && !sat;
  assign report = q_pop && (q_item.cls == CLS_LAST);
  assign qzero = q_pop && (q_item.cls == CLS_QUERY) && !tbl_ok;
  assign start = q_pop && (q_item.cls == CLS_QUERY) && tbl_ok;
  assign load = report || qzero || (busy && lkp_rsp.done && out_free);

  assign lkp_req.start = start;
  assign lkp_req.take = busy && lkp_rsp.done && out_free;
  assign lkp_req.sample_pos = q_item.sample_pos;
  assign lkp_req.samples = total_samples;
  assign lkp_req.bytes = total_bytes;

  always_comb begin
    unique case (byte_count[1:0])
      2'd0: magic = 8'h4F;
      2'd1: magic = 8'h67;
      2'd2: magic = 8'h67;
      2'd3: magic = 8'h53;
      default: magic = 8'h53;
    endcase
  end

  // Header walk: one byte per cycle while no lookup is busy.
  always_comb begin
    phase_next = phase;
    byte_count_next = byte_count;
    seg_count_next = seg_count;
    pkt_len_next = pkt_len;
    seg_rem_next = seg_rem;
    data_idx_next = data_idx;
    pend_samples_next = pend_samples;
    pend_size_next = pend_size;
    run_off_next = run_off;
    err_next = err;
    total_samples_next = total_samples;
    total_bytes_next = total_bytes;
    table_valid_next = table_valid;
    tbl_wr.we = 1'b0;
    tbl_wr.addr = 7'(data_idx - 7'd9);
    tbl_wr.data = run_off;
    p = {1'b0, byte_count};
    pstart = HDR_LEN + 18'(seg_count);
    pend = pstart + 18'(pkt_len);
    len = {b, seg_rem[7:0]};
    rem_dec = seg_rem - 16'd1;
    size = sat ? 18'd131072 : p + 18'd1;
    pstart_n = '0;
    status = ST_OK;

    if (step) begin
      if (byte_count < 17'd4 && b != magic) begin
        err_next[0] = 1'b1;
      end
      if (byte_count == 17'd26) begin
        seg_count_next = b;
      end
      unique case (phase)
        PH_HEAD: begin
          if (p >= HDR_LEN) begin
            if (p < pstart) begin
              pkt_len_next = pkt_len + 16'(b);
            end else if (p == pstart) begin
              if (b != MARKER) begin
                err_next[1] = 1'b1;
              end
              phase_next = (pkt_len == '0) ? PH_DONE : PH_LENLO;
            end
          end
        end
        PH_LENLO: begin
          if (p + 18'd2 > pend) begin
            phase_next = PH_DONE;
          end else begin
            seg_rem_next = 16'(b);
            phase_next = PH_LENHI;
          end
        end
        PH_LENHI: begin
          if (len == '0 || p + 18'd1 + 18'(len) > pend) begin
            phase_next = PH_DONE;
          end else begin
            seg_rem_next = len;
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          seg_rem_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_LENLO;
          end else if (b == 8'd0 && seg_rem == SEEK_SEG_LEN) begin
            data_idx_next = '0;
            phase_next = PH_SEEK;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_SEEK: begin
          if (data_idx < 7'd4) begin
            pend_samples_next[8*data_idx[1:0] +: 8] = b;
          end else if (data_idx < 7'd8) begin
            pend_size_next[8*data_idx[1:0] +: 8] = b;
          end else if (data_idx == 7'd8) begin
            run_off_next = -OFF_W'(step_rom(b));
          end else if (data_idx < 7'd109) begin
            run_off_next = run_off + OFF_W'(step_rom(b));
            tbl_wr.we = 1'b1;
            tbl_wr.data = run_off_next;
          end
          data_idx_next = data_idx + 7'd1;
          seg_rem_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_LENLO;
          end
        end
        PH_SKIP: begin
          seg_rem_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next = PH_LENLO;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
      if (!sat) begin
        byte_count_next = byte_count + 17'd1;
      end
    end

    if (report) begin
      pstart_n = HDR_LEN + 18'(seg_count_next);
      if (err_next[0] || size < 18'd28 || size < pstart_n) begin
        status = ST_NOT_OGG;
      end else if (pkt_len_next == '0 || size < pstart_n + 18'(pkt_len_next)
                   || err_next[1]) begin
        status = ST_BAD_PACKET;
      end else if (pend_samples_next == '0) begin
        status = ST_NO_TABLE;
      end else begin
        status = ST_OK;
      end
      if (status == ST_OK) begin
        total_samples_next = pend_samples_next;
        total_bytes_next = pend_size_next;
        table_valid_next = 1'b1;
      end else begin
        table_valid_next = 1'b0;
      end
      phase_next = PH_HEAD;
      byte_count_next = '0;
      seg_count_next = '0;
      pkt_len_next = '0;
      seg_rem_next = '0;
      data_idx_next = '0;
      pend_samples_next = '0;
      pend_size_next = '0;
      run_off_next = '0;
      err_next = '0;
    end
  end

  always_comb begin
    out_next.kind = report ? KIND_REPORT : KIND_ANSWER;
    out_next.parse_status = report ? status : ST_OK;
    out_next.table_ready = table_valid_next;
    out_next.byte_pos = (report || qzero) ? '0 : lkp_rsp.byte_pos;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= out_next;
    end
    if (rst) begin
      phase <= PH_HEAD;
      byte_count <= '0;
      seg_count <= '0;
      pkt_len <= '0;
      seg_rem <= '0;
      data_idx <= '0;
      pend_samples <= '0;
      pend_size <= '0;
      run_off <= '0;
      err <= '0;
      total_samples <= '0;
      total_bytes <= '0;
      table_valid <= 1'b0;
      busy <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      byte_count <= byte_count_next;
      seg_count <= seg_count_next;
      pkt_len <= pkt_len_next;
      seg_rem <= seg_rem_next;
      data_idx <= data_idx_next;
      pend_samples <= pend_samples_next;
      pend_size <= pend_size_next;
      run_off <= run_off_next;
      err <= err_next;
      total_samples <= total_samples_next;
      total_bytes <= total_bytes_next;
      table_valid <= table_valid_next;
      if (start) begin
        busy <= 1'b1;
      end else if (lkp_req.take) begin
        busy <= 1'b0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ogg_seek_table_parse_and_lookup_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Seek-table parser and sample-to-byte position lookup.
// The req channel carries one transaction per item: either one byte of a
// captured page header (mode 0, header_last marking the final byte) or a
// sample position query (mode 1). The rsp channel returns a parse report for
// every final header byte and an answer for every query; other header bytes
// produce nothing. Both channels use valid/stall handshakes.
// Transactions enter a two-entry queue; while no lookup runs, the header walk
// takes one byte per cycle, and a report is registered after its queue slot.
// A query with a committed table and a non-zero byte total runs a restoring
// divider on a POS_BITS+7+FRAC_BITS-bit dividend, two table reads, a 22-bit
// shift-add multiplier and, when the interpolated value is positive, a 32-bit
// one; the queue stalls behind it. A query without such a table is
// answered at header-byte speed with position zero.
// Synchronous reset empties the queue, drops any pending response, clears the
// totals and the table-valid flag; the offset table itself is not cleared.
// When rsp_stall is held, the response register keeps its transaction;
// header bytes pass on, the queue fills behind a result and req_stall rises.
module ogg_seek_table_parse_and_lookup_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire osp_pkg::in_item_t   req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output osp_pkg::out_item_t       rsp
);
  import osp_pkg::*;

  logic                q_valid;
  q_item_t             q_item;
  logic                q_pop;
  lkp_req_t            lkp_req;
  lkp_rsp_t            lkp_rsp;
  tbl_wr_t             tbl_wr;
  logic [TBL_AW-1:0]   tbl_raddr;
  logic [OFF_W-1:0]    tbl_rdata;

  osp_front u_front (
    .clk, .rst, .req_valid, .req_stall, .req,
    .q_valid, .q_item, .q_pop
  );

  osp_back u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop,
    .lkp_req, .lkp_rsp, .tbl_wr,
    .rsp_valid, .rsp_stall, .rsp
  );

  osp_lookup #(.FRAC_BITS(FRAC_BITS)) u_lookup (
    .clk, .rst, .req(lkp_req), .rsp(lkp_rsp),
    .tbl_addr(tbl_raddr), .tbl_data(tbl_rdata)
  );

  osp_ram #(.WIDTH(OFF_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk,
    .we(tbl_wr.we), .waddr(tbl_wr.addr), .wdata(tbl_wr.data),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );
endmodule
`default_nettype wire

// ===== rtl/osp_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module osp_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_stall,
  input wire osp_pkg::in_item_t   req,
  input wire logic                rsp_valid,
  input wire logic                rsp_stall,
  input wire osp_pkg::out_item_t  rsp
);
  import osp_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) !rst && $past(rst) |-> !rsp_valid)
    else $error("response valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_report_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_REPORT |-> rsp.byte_pos == '0)
    else $error("parse report carries a byte position");

  a_ready_match: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_REPORT |->
      rsp.table_ready == (rsp.parse_status == ST_OK))
    else $error("table_ready disagrees with parse status");

  a_answer_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_ANSWER |->
      rsp.parse_status == ST_OK && (rsp.table_ready || rsp.byte_pos == '0))
    else $error("query answer malformed");
endmodule

bind ogg_seek_table_parse_and_lookup_core osp_chk u_chk (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import osp_pkg::*;

  // Geometry of the header walk and other test settings.
  localparam int unsigned HEAD_LEN = 27;
  localparam int unsigned SEEK_LEN = 110;
  localparam int unsigned COUNT_MAX = 131071;
  localparam int FRAC = 16;
  localparam logic [7:0] PKT_MARKER = 8'h81;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned ROUNDS = 7;

  typedef enum int unsigned {
    W_HEAD, W_LENLO, W_LENHI, W_TYPE, W_SEEK, W_SKIP, W_DONE
  } walk_e;

  typedef struct {
    in_item_t    item;
    bit          drain;
    int unsigned grp;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  ogg_seek_table_parse_and_lookup_core DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the parser and the committed seek table.
  walk_e       walk;
  int unsigned bcnt, nseg, plen, srem, didx, psamp, psize;
  int          roff;
  int          offs [100];
  int unsigned tsamp, tbytes;
  bit          tvalid;
  bit [1:0]    errs;

  stim_t       pending [$];
  out_item_t   expected [$];
  logic [7:0]  cap [$];
  int unsigned last_samples;
  int unsigned made, n_res;
  int unsigned failures, acc_in, idle_cycles;
  int unsigned st_seen [4];
  int unsigned n_answers, n_nonzero;
  int unsigned cur_grp = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          req_taken = 1'b0;

  function automatic void clear_walk();
    walk = W_HEAD;
    bcnt = 0; nseg = 0; plen = 0; srem = 0; didx = 0;
    psamp = 0; psize = 0; roff = 0; errs = 2'b00;
  endfunction

  // One header byte through the segment walker.
  function automatic void absorb(logic [7:0] b);
    int unsigned p, pstart, pfin, len, d;
    logic [7:0]  magic [4];
    bit          cand;
    magic = '{8'h4F, 8'h67, 8'h67, 8'h53};
    p = bcnt;
    pstart = HEAD_LEN + nseg;
    pfin = pstart + plen;
    if (p < 4 && b != magic[p]) errs[0] = 1'b1;
    if (p == 26) nseg = b;
    case (walk)
      W_HEAD: begin
        if (p >= HEAD_LEN) begin
          if (p < pstart) begin
            plen += b;
          end else if (p == pstart) begin
            if (b != PKT_MARKER) errs[1] = 1'b1;
            walk = (plen == 0) ? W_DONE : W_LENLO;
          end
        end
      end
      W_LENLO: begin
        if (p + 2 > pfin) begin
          walk = W_DONE;
        end else begin
          srem = b;
          walk = W_LENHI;
        end
      end
      W_LENHI: begin
        len = srem | (int'(b) << 8);
        if (len == 0 || p + 1 + len > pfin) begin
          walk = W_DONE;
        end else begin
          srem = len;
          walk = W_TYPE;
        end
      end
      W_TYPE: begin
        cand = (b == 8'h00) && (srem == SEEK_LEN);
        srem--;
        if (srem == 0) walk = W_LENLO;
        else if (cand) begin
          didx = 0;
          walk = W_SEEK;
        end else walk = W_SKIP;
      end
      W_SEEK: begin
        d = didx;
        if (d < 4) psamp[8*d +: 8] = b;
        else if (d < 8) psize[8*(d-4) +: 8] = b;
        else if (d == 8) roff = -int'(STEP_ROM[b]);
        else if (d < 109) begin
          roff += int'(STEP_ROM[b]);
          offs[d-9] = roff;
        end
        didx = (d + 1) & 32'h7F;
        srem--;
        if (srem == 0) walk = W_LENLO;
      end
      W_SKIP: begin
        srem--;
        if (srem == 0) walk = W_LENLO;
      end
      default: ;
    endcase
    if (bcnt < COUNT_MAX) bcnt++;
  endfunction

  // Sample position to byte position by linear interpolation in the table,
  // extrapolating past the clamped ends and saturating at the port width.
  function automatic logic [POS_BITS-1:0] seek_estimate(logic [POS_BITS-1:0] pos);
    logic [127:0]        rel, prod;
    logic signed [127:0] tv, dv, pv, vv;
    int unsigned         k;
    int                  prev, dlt;
    if (!tvalid || tsamp == 0 || tbytes == 0) return '0;
    rel = ({88'd0, pos} * 128'd100 << FRAC) / tsamp;
    if (rel[127:FRAC] > 99) k = 99;
    else k = int'(rel[FRAC +: 7]);
    if (k < 1) k = 1;
    tv = $signed(rel) - $signed(128'(k) << FRAC);
    prev = offs[k-1];
    dlt = offs[k] - prev;
    dv = dlt;
    pv = prev;
    vv = dv * tv + (pv <<< FRAC);
    if (vv <= 0) return '0;
    prod = vv;
    prod = (prod * tbytes) >> (FRAC + 16);
    if (prod > 128'(POS_MAX)) return POS_MAX;
    return prod[POS_BITS-1:0];
  endfunction

  // Work out what an accepted transaction should produce.
  function automatic void predict(in_item_t it);
    out_item_t   o;
    int unsigned size, pstart;
    bit          sat;
    o = '0;
    if (it.mode == MODE_QUERY) begin
      o.kind = KIND_ANSWER;
      o.parse_status = ST_OK;
      o.table_ready = tvalid;
      o.byte_pos = seek_estimate(it.sample_pos);
      expected.push_back(o);
      return;
    end
    sat = bcnt >= COUNT_MAX;
    size = sat ? COUNT_MAX + 1 : bcnt + 1;
    if (!sat) absorb(it.header_byte);
    if (!it.header_last) return;
    pstart = HEAD_LEN + nseg;
    if (errs[0] || size < HEAD_LEN + 1 || size < pstart) o.parse_status = ST_NOT_OGG;
    else if (plen == 0 || size < pstart + plen || errs[1]) o.parse_status = ST_BAD_PACKET;
    else if (psamp == 0) o.parse_status = ST_NO_TABLE;
    else o.parse_status = ST_OK;
    if (o.parse_status == ST_OK) begin
      tsamp = psamp;
      tbytes = psize;
      tvalid = 1'b1;
    end else begin
      tvalid = 1'b0;
    end
    clear_walk();
    o.kind = KIND_REPORT;
    o.table_ready = tvalid;
    expected.push_back(o);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------
  task automatic queue_item(in_item_t it, int unsigned grp);
    stim_t s;
    s.item = it;
    s.drain = 1'b0;
    s.grp = grp;
    pending.push_back(s);
    made++;
    if (it.mode == MODE_QUERY || it.header_last) n_res++;
  endtask

  task automatic queue_query(logic [POS_BITS-1:0] pos, int unsigned grp);
    in_item_t it;
    it.mode = MODE_QUERY;
    it.header_byte = 8'($urandom);
    it.header_last = 1'($urandom);
    it.sample_pos = pos;
    queue_item(it, grp);
  endtask

  // Positions biased towards the range of the latest table, with the extremes
  // and fully random values mixed in.
  function automatic logic [POS_BITS-1:0] pick_pos();
    logic [63:0] w;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return POS_MAX;
      2: return POS_BITS'({$urandom, $urandom});
      default: begin
        w = 64'(last_samples) * $urandom_range(0, 125) / 100 + $urandom_range(0, 3);
        return w[POS_BITS-1:0];
      end
    endcase
  endfunction

  // Sends the bytes held in cap as one capture; now and then a query slips
  // in between bytes, so lookups also run while a capture is in progress.
  task automatic queue_capture(int unsigned grp, bit mix);
    in_item_t it;
    for (int i = 0; i < cap.size(); i++) begin
      if (mix && $urandom_range(0, 63) == 0) queue_query(pick_pos(), grp);
      it.mode = MODE_BYTE;
      it.header_byte = cap[i];
      it.header_last = (i == cap.size() - 1);
      it.sample_pos = POS_BITS'({$urandom, $urandom});
      queue_item(it, grp);
    end
  endtask

  task automatic add_segment(bit seek);
    int unsigned len;
    logic [31:0] v;
    len = seek ? SEEK_LEN : $urandom_range(1, 12);
    cap.push_back(len[7:0]);
    cap.push_back(len[15:8]);
    cap.push_back(seek ? 8'h00 : 8'($urandom_range(0, 255)));
    if (seek) begin
      case ($urandom_range(0, 9))
        0: v = 0;
        1: v = $urandom_range(1, 300);
        2: v = '1;
        default: v = $urandom;
      endcase
      if (v != 0) last_samples = v;
      for (int i = 0; i < 4; i++) cap.push_back(v[8*i +: 8]);
      case ($urandom_range(0, 7))
        0: v = 0;
        1: v = '1;
        default: v = $urandom;
      endcase
      for (int i = 0; i < 4; i++) cap.push_back(v[8*i +: 8]);
      for (int i = 0; i < 101; i++) cap.push_back(8'($urandom));
    end else begin
      for (int i = 1; i < len; i++) cap.push_back(8'($urandom));
    end
  endtask

  // A well-formed page carrying a seek table, sometimes with extra segments,
  // a second candidate (the later one must win) and a random defect.
  task automatic build_page(int unsigned trailing);
    logic [7:0]  body [$];
    int unsigned plen_b, segs, pos;
    cap = {};
    cap.push_back(PKT_MARKER);
    if ($urandom_range(0, 1)) add_segment(1'b0);
    add_segment(1'b1);
    if ($urandom_range(0, 3) == 0) add_segment(1'b1);
    if ($urandom_range(0, 1)) add_segment(1'b0);
    body = cap;
    plen_b = body.size();
    segs = (plen_b + 254) / 255 + $urandom_range(0, 1);
    cap = '{8'h4F, 8'h67, 8'h67, 8'h53};
    for (int i = 4; i < 26; i++) cap.push_back(8'($urandom));
    cap.push_back(segs[7:0]);
    for (int i = 0; i < segs; i++) cap.push_back(8'(plen_b / segs + (i < plen_b % segs)));
    cap = {cap, body};
    for (int i = 0; i < trailing; i++) cap.push_back(8'($urandom));
    case ($urandom_range(0, 9))
      0: begin
        pos = $urandom_range(0, cap.size() - 1);
        cap[pos] = cap[pos] ^ 8'($urandom_range(1, 255));
      end
      1: cap = cap[0:$urandom_range(0, cap.size() - 1)];
      2: cap[HEAD_LEN + segs] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endtask

  task automatic build_noise();
    cap = {};
    if ($urandom_range(0, 1)) cap = '{8'h4F, 8'h67, 8'h67, 8'h53};
    repeat ($urandom_range(1, 40)) cap.push_back(8'($urandom));
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers one transaction at a time and holds it until accepted.
  // ---------------------------------------------------------------------
  function automatic int unsigned send_gap(int unsigned g);
    return (g == 0) ? 34 : (g == 1) ? 50 : 0;
  endfunction

  function automatic int unsigned recv_gap(int unsigned g);
    return (g == 0) ? 50 : (g == 1) ? 34 : 0;
  endfunction

  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending.size() == 0) begin
        req_valid <= 1'b0;
      end else if (pending[0].drain) begin
        // Sender pause: nothing more is offered until every result is back.
        req_valid <= 1'b0;
        if (expected.size() == 0) pending[0].drain = 1'b0;
      end else if ($urandom_range(0, 99) < send_gap(pending[0].grp)) begin
        req_valid <= 1'b0;
      end else begin
        req <= pending[0].item;
        req_valid <= 1'b1;
        cur_grp <= pending[0].grp;
        pending.pop_front();
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block fills up
  // and pushes back on its input side.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!hold_done && acc_in >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_gap(cur_grp));
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compares results, then predicts from the accepted transaction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t e;
    bit        moved;
    moved = 1'b0;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        moved = 1'b1;
        if (expected.size() == 0) begin
          $error("result transaction with nothing expected: %p", rsp);
          failures++;
        end else begin
          e = expected.pop_front();
          if (rsp.kind != e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, rsp.kind);
            failures++;
          end
          if (rsp.parse_status != e.parse_status) begin
            $error("parse_status: expected %0d, got %0d", e.parse_status, rsp.parse_status);
            failures++;
          end
          if (rsp.table_ready != e.table_ready) begin
            $error("table_ready: expected %0d, got %0d", e.table_ready, rsp.table_ready);
            failures++;
          end
          if (rsp.byte_pos != e.byte_pos) begin
            $error("byte_pos: expected %0h, got %0h", e.byte_pos, rsp.byte_pos);
            failures++;
          end
          if (e.kind == KIND_REPORT) st_seen[e.parse_status]++;
          else begin
            n_answers++;
            if (e.byte_pos != 0) n_nonzero++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        moved = 1'b1;
        acc_in++;
        predict(req);
      end
      // Watchdog on cycles in which neither channel completes a transaction.
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    in_item_t it;
    int unsigned grp;
    clear_walk();
    foreach (offs[i]) offs[i] = 0;
    tsamp = 0; tbytes = 0; tvalid = 1'b0;
    last_samples = 1000;

    // Directed opening: lookups with no table held, then captures that fail
    // on the magic word or are too short to be a page, and one more lookup.
    queue_query('0, 0);
    queue_query(POS_MAX, 0);
    cap = '{8'h58};
    queue_capture(0, 1'b0);
    cap = '{8'h4F, 8'h67, 8'h67, 8'h53};
    queue_capture(0, 1'b0);
    cap = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F};
    queue_capture(0, 1'b0);
    cap = '{8'h4F};
    queue_capture(0, 1'b0);
    queue_query(POS_BITS'({$urandom, $urandom}), 0);

    // Random part in three idling groups; a page with a seek table is built
    // first so that lookups have something to work on early.
    for (int r = 0; r < ROUNDS; r++) begin
      grp = r * 3 / ROUNDS;
      if (r == ROUNDS / 3) begin
        // Next transaction waits until the block has returned everything.
        queue_query(pick_pos(), grp);
        pending[pending.size()-1].drain = 1'b1;
      end
      case (r == 0 ? 0 : $urandom_range(0, 9))
        0, 1, 2: begin
          build_page($urandom_range(0, 3));
          queue_capture(grp, 1'b1);
        end
        3: begin
          build_noise();
          queue_capture(grp, 1'b1);
        end
        default: repeat ($urandom_range(1, 5)) queue_query(pick_pos(), grp);
      endcase
    end
    // A final burst of lookups against whatever table is held, with no idling.
    repeat (6) queue_query(pick_pos(), 2);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || req_valid || expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected.size() != 0) begin
      $error("%0d expected results never arrived", expected.size());
      failures++;
    end
    $display("covered %0d input transactions: reports ok/not-ogg/bad-packet/no-table %0d/%0d/%0d/%0d",
             acc_in, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    $display("lookups answered %0d, of which %0d gave a non-zero byte position",
             n_answers, n_nonzero);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
